[rtl/core/nbsg_pkg.sv]
// shared types, constants and helper functions of the n-body step block
`default_nettype none
package nbsg_pkg;

  // sizing
  localparam int MAX_BODIES = 1024;
  localparam int GRID_X     = 64;
  localparam int GRID_Y     = 32;
  localparam int GRID_Z     = 128;
  localparam int BODY_W     = $clog2(MAX_BODIES);
  localparam int NCELLS     = GRID_X * GRID_Y * GRID_Z;
  localparam int CELL_W     = $clog2(NCELLS);
  localparam int TS_W       = 47;
  localparam int CNT_W      = 11;
  localparam int DIV_STEPS  = 72;

  typedef logic signed [47:0] q_t;
  typedef logic [47:0]        u48_t;
  typedef q_t [2:0]           vec3_t;

  localparam q_t   QMAX  = 48'sh7FFF_FFFF_FFFF;
  localparam q_t   QMIN  = 48'sh8000_0000_0000;
  localparam u48_t UCAPP = 48'h7FFF_FFFF_FFFF;
  localparam u48_t UCAPN = 48'h8000_0000_0000;
  localparam logic signed [49:0] QMAX50 = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] QMIN50 = 50'sh3_8000_0000_0000;

  // input ops
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic {
    CFG_TIME_STEP = 1'b0,
    CFG_BODIES    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] body;
    q_t         load_x;
    q_t         load_y;
    q_t         load_z;
  } in_item_t;

  typedef struct packed {
    q_t               out_x;
    q_t               out_y;
    q_t               out_z;
    logic [CNT_W-1:0] collision_count;
  } out_item_t;

  // arithmetic unit
  typedef enum logic {
    AR_MUL = 1'b0,
    AR_DIV = 1'b1
  } ar_op_t;

  typedef struct packed {
    logic   start;
    ar_op_t op;
    logic   cap_neg;
  } ar_req_t;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_MUL,
    AS_DIV,
    AS_SAT
  } ar_state_t;

  // main sequencer
  typedef enum logic [4:0] {
    S_GCLR,
    S_IDLE,
    S_RD_WAIT,
    S_FIN,
    S_FCLR,
    S_J_RD,
    S_J_WAIT,
    S_K_RD,
    S_K_WAIT,
    S_K_SQ,
    S_K_DD,
    S_K_DIV,
    S_K_WR,
    S_J_WR,
    S_B_RD,
    S_B_WAIT,
    S_B_K1,
    S_B_MV,
    S_B_GRD,
    S_B_GWT,
    S_B_K2,
    S_B_ORD,
    S_B_OWT,
    S_B_WR,
    S_B_WR2,
    S_MC_RD,
    S_MC_WR
  } st_t;

  // saturate a widened value to q range
  function automatic q_t sat_q(input logic signed [49:0] v);
    if (v > QMAX50) return QMAX;
    if (v < QMIN50) return QMIN;
    return v[47:0];
  endfunction

  function automatic logic signed [49:0] sext50(input q_t a);
    return {{2{a[47]}}, a};
  endfunction

  function automatic u48_t mag_q(input q_t a);
    return a[47] ? u48_t'(-a) : u48_t'(a);
  endfunction

  function automatic logic signed [49:0] apply_sign(input u48_t m, input logic neg);
    logic signed [49:0] w;
    w = $signed({2'b00, m});
    return neg ? -w : w;
  endfunction

endpackage
`default_nettype wire

[rtl/core/nbsg_arith.sv]
// shared multi-cycle unit: saturating q24.24 magnitude multiply and divide
`default_nettype none
module nbsg_arith import nbsg_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire ar_req_t req,
  input  wire u48_t    a,
  input  wire u48_t    b,
  output logic         done,
  output u48_t         res
);

  ar_state_t   st_r, st_nxt;
  logic [6:0]  cnt_r;
  u48_t        a_r, b_r;
  logic        cap_neg_r;
  logic [95:0] acc_r;
  logic [47:0] rem_r;
  logic [71:0] dvd_r, quo_r;

  logic [23:0] sa, sb;
  logic [47:0] pp;
  logic [95:0] pp_sh;
  logic [48:0] trial;
  logic        fit;
  u48_t        cap;

  // partial product of one 24-bit half pair
  always_comb begin
    sa = cnt_r[1] ? a_r[47:24] : a_r[23:0];
    sb = cnt_r[0] ? b_r[47:24] : b_r[23:0];
    pp = sa * sb;
    case ({cnt_r[1], cnt_r[0]})
      2'b00:   pp_sh = {48'b0, pp};
      2'b11:   pp_sh = {pp, 48'b0};
      default: pp_sh = {24'b0, pp, 24'b0};
    endcase
  end

  // one restoring division step
  always_comb begin
    trial = {rem_r, dvd_r[71]};
    fit   = trial >= {1'b0, b_r};
  end

  // saturation limit of the final value
  always_comb begin
    cap = cap_neg_r ? UCAPN : UCAPP;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      AS_IDLE: if (req.start) st_nxt = (req.op == AR_DIV) ? AS_DIV : AS_MUL;
      AS_MUL:  if (cnt_r == 7'd3) st_nxt = AS_SAT;
      AS_DIV:  if (cnt_r == 7'(DIV_STEPS - 1)) st_nxt = AS_SAT;
      AS_SAT:  st_nxt = AS_IDLE;
      default: st_nxt = AS_IDLE;
    endcase
  end

  logic div_mode_r;

  // outputs
  always_comb begin
    done = (st_r == AS_SAT);
    if (div_mode_r) begin
      res = (quo_r > {24'b0, cap}) ? cap : quo_r[47:0];
    end else begin
      res = (acc_r[95:24] > {24'b0, cap}) ? cap : acc_r[71:24];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= AS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (st_r)
      AS_IDLE: begin
        a_r        <= a;
        b_r        <= b;
        cap_neg_r  <= req.cap_neg;
        div_mode_r <= (req.op == AR_DIV);
        cnt_r      <= 7'd0;
        acc_r      <= 96'b0;
        rem_r      <= 48'b0;
        quo_r      <= 72'b0;
        dvd_r      <= {a, 24'b0};
      end
      AS_MUL: begin
        acc_r <= acc_r + pp_sh;
        cnt_r <= cnt_r + 7'd1;
      end
      AS_DIV: begin
        rem_r <= fit ? 48'(trial - {1'b0, b_r}) : trial[47:0];
        quo_r <= {quo_r[70:0], fit};
        dvd_r <= {dvd_r[70:0], 1'b0};
        cnt_r <= cnt_r + 7'd1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/nbody_step_with_grid_collisions.sv]
// top level: body stores, occupancy grid and the step sequencer
// A load gives no item; a read puts its item on the output by way of the position read
// register, res_r and the output register, once that register is free. A step gives one
// item with the collision count: each body pair needs four multiplies and three divides
// on the one shared arithmetic unit, whose divider is bit-serial; a pair whose squared
// divisor is zero skips its divides.
// After reset the block clears the occupancy grid, one cell a cycle, and holds in_stall
// high until all NCELLS (262144) cells are clear; configuration writes are taken meanwhile.
// Items are taken one at a time while the previous result may still wait at the output
// register.
`default_nettype none
module nbody_step_with_grid_collisions import nbsg_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire in_item_t        in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output out_item_t            out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic            cfg_index,
  input  wire logic [TS_W-1:0] cfg_data
);

  // memories
  vec3_t             pos_mem [MAX_BODIES];
  vec3_t             vel_mem [MAX_BODIES];
  vec3_t             frc_mem [MAX_BODIES];
  logic [BODY_W:0]   grid_mem [NCELLS];
  logic [CELL_W-1:0] mark_mem [MAX_BODIES];

  vec3_t             pos_rd, vel_rd, frc_rd;
  logic [BODY_W:0]   grid_rd;
  logic [CELL_W-1:0] mark_rd;

  logic              pos_we, vel_we, frc_we, grid_we, mark_we;
  logic [BODY_W-1:0] pos_waddr, vel_waddr, frc_waddr, mark_waddr;
  logic [BODY_W-1:0] pos_raddr, vel_raddr, frc_raddr, mark_raddr;
  logic [CELL_W-1:0] grid_waddr, grid_raddr;
  vec3_t             pos_wdata, vel_wdata, frc_wdata;
  logic [BODY_W:0]   grid_wdata;

  // sequencer state
  st_t               st_r, st_nxt;
  logic [TS_W-1:0]   ts_r;
  logic [CNT_W-1:0]  nbod_r, n_r, j_r, k_r, coll_r, mark_cnt_r;
  logic [1:0]        ax_r;
  logic              wait_r, hit_r, ingrid_r, rd_ok_r;
  vec3_t             pj_r, fj_r, fk_r, vj_r, vo_r, d_r;
  u48_t              dist_r, dd_r;
  logic [BODY_W-1:0] owner_r;
  logic [CELL_W-1:0] cell_r;
  logic [CELL_W:0]   clr_r;
  out_item_t         res_r, out_r;
  logic              out_valid_r;

  // arithmetic unit
  ar_req_t ar_req;
  u48_t    ar_a, ar_b, ar_res;
  logic    ar_done;

  nbsg_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ar_req),
    .a     (ar_a),
    .b     (ar_b),
    .done  (ar_done),
    .res   (ar_res)
  );

  logic in_acc, out_free, step_done, ax_last;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign step_done = wait_r && ar_done;
  assign ax_last   = (ax_r == 2'd2);

  // signed result of the current multiply or divide
  logic              ar_neg;
  logic signed [49:0] ar_s, ar_half;
  always_comb begin
    ar_s    = apply_sign(ar_res, ar_neg);
    ar_half = (ar_s + $signed({49'b0, ar_s[49]})) >>> 1;
  end

  // pair differences straight from the read port
  vec3_t d_new;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d_new[a] = sat_q(sext50(pos_rd[a]) - sext50(pj_r[a]));
    end
  end

  // grid cell of the moved body
  logic              in_grid;
  logic [CELL_W-1:0] cell_new;
  always_comb begin
    in_grid = !pj_r[0][47] && (pj_r[0] != 48'sd0) && (pj_r[0][47:24] < 24'(GRID_X)) &&
              !pj_r[1][47] && (pj_r[1] != 48'sd0) && (pj_r[1][47:24] < 24'(GRID_Y)) &&
              !pj_r[2][47] && (pj_r[2] != 48'sd0) && (pj_r[2][47:24] < 24'(GRID_Z));
    cell_new = (CELL_W'(pj_r[0][47:24]) * CELL_W'(GRID_Y) + CELL_W'(pj_r[1][47:24]))
               * CELL_W'(GRID_Z) + CELL_W'(pj_r[2][47:24]);
  end

  // wall reflection
  function automatic logic at_wall(input q_t p, input logic [23:0] topm1);
    return (mag_q(p) < 48'h100_0000) || (!p[47] && p[47:24] == topm1);
  endfunction

  vec3_t v_wall;
  always_comb begin
    v_wall[0] = at_wall(pj_r[0], 24'(GRID_X - 1)) ? sat_q(-sext50(vj_r[0])) : vj_r[0];
    v_wall[1] = at_wall(pj_r[1], 24'(GRID_Y - 1)) ? sat_q(-sext50(vj_r[1])) : vj_r[1];
    v_wall[2] = at_wall(pj_r[2], 24'(GRID_Z - 1)) ? sat_q(-sext50(vj_r[2])) : vj_r[2];
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_GCLR:    if (clr_r == (CELL_W+1)'(NCELLS - 1)) st_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          unique case (op_t'(in_data.op))
            OP_READ: st_nxt = S_RD_WAIT;
            OP_STEP: st_nxt = S_FCLR;
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      S_RD_WAIT: st_nxt = S_FIN;
      S_FIN:     if (out_free) st_nxt = S_IDLE;
      S_FCLR:    if (j_r >= n_r) st_nxt = S_J_RD;
      S_J_RD:    st_nxt = (j_r >= n_r) ? S_B_RD : S_J_WAIT;
      S_J_WAIT:  st_nxt = S_K_RD;
      S_K_RD:    st_nxt = (k_r >= n_r) ? S_J_WR : S_K_WAIT;
      S_K_WAIT:  st_nxt = S_K_SQ;
      S_K_SQ:    if (step_done && ax_last) st_nxt = S_K_DD;
      S_K_DD:    if (step_done) st_nxt = (ar_res == 48'b0) ? S_K_WR : S_K_DIV;
      S_K_DIV:   if (step_done && ax_last) st_nxt = S_K_WR;
      S_K_WR:    st_nxt = S_K_RD;
      S_J_WR:    st_nxt = S_J_RD;
      S_B_RD:    st_nxt = (j_r >= n_r) ? S_MC_RD : S_B_WAIT;
      S_B_WAIT:  st_nxt = S_B_K1;
      S_B_K1:    if (step_done && ax_last) st_nxt = S_B_MV;
      S_B_MV:    if (step_done && ax_last) st_nxt = S_B_GRD;
      S_B_GRD:   st_nxt = S_B_GWT;
      S_B_GWT:   st_nxt = S_B_K2;
      S_B_K2:    if (step_done && ax_last) st_nxt = hit_r ? S_B_ORD : S_B_WR;
      S_B_ORD:   st_nxt = S_B_OWT;
      S_B_OWT:   st_nxt = S_B_WR;
      S_B_WR:    st_nxt = hit_r ? S_B_WR2 : S_B_RD;
      S_B_WR2:   st_nxt = S_B_RD;
      S_MC_RD:   st_nxt = (k_r >= mark_cnt_r) ? S_FIN : S_MC_WR;
      S_MC_WR:   st_nxt = S_MC_RD;
      default:   st_nxt = S_IDLE;
    endcase
  end

  // outputs: handshakes, memory controls, arithmetic requests
  always_comb begin
    in_stall   = (st_r != S_IDLE);
    cfg_ready  = 1'b1;
    pos_we     = 1'b0;
    vel_we     = 1'b0;
    frc_we     = 1'b0;
    grid_we    = 1'b0;
    mark_we    = 1'b0;
    pos_waddr  = j_r[BODY_W-1:0];
    vel_waddr  = j_r[BODY_W-1:0];
    frc_waddr  = j_r[BODY_W-1:0];
    mark_waddr = mark_cnt_r[BODY_W-1:0];
    pos_raddr  = j_r[BODY_W-1:0];
    vel_raddr  = j_r[BODY_W-1:0];
    frc_raddr  = j_r[BODY_W-1:0];
    mark_raddr = k_r[BODY_W-1:0];
    grid_waddr = cell_r;
    grid_raddr = cell_new;
    pos_wdata  = pj_r;
    vel_wdata  = hit_r ? vo_r : v_wall;
    frc_wdata  = fj_r;
    grid_wdata = {1'b1, j_r[BODY_W-1:0]};
    ar_req     = '{start: 1'b0, op: AR_MUL, cap_neg: 1'b0};
    ar_a       = mag_q(d_r[ax_r]);
    ar_b       = mag_q(d_r[ax_r]);
    ar_neg     = 1'b0;
    unique case (st_r)
      S_GCLR: begin
        grid_we    = 1'b1;
        grid_waddr = clr_r[CELL_W-1:0];
        grid_wdata = '0;
      end
      S_IDLE: begin
        pos_raddr = BODY_W'(in_data.body);
        if (in_acc && op_t'(in_data.op) == OP_LOAD &&
            {1'b0, in_data.body} < 11'(MAX_BODIES)) begin
          pos_we    = 1'b1;
          vel_we    = 1'b1;
          pos_waddr = BODY_W'(in_data.body);
          vel_waddr = BODY_W'(in_data.body);
          pos_wdata = '{in_data.load_z, in_data.load_y, in_data.load_x};
          vel_wdata = '0;
        end
      end
      S_FCLR: begin
        frc_we    = (j_r < n_r);
        frc_wdata = '0;
      end
      S_K_RD: begin
        pos_raddr = k_r[BODY_W-1:0];
        frc_raddr = k_r[BODY_W-1:0];
      end
      S_K_SQ: begin
        ar_req.start = !wait_r;
      end
      S_K_DD: begin
        ar_req.start = !wait_r;
        ar_a         = dist_r;
        ar_b         = dist_r;
      end
      S_K_DIV: begin
        ar_req = '{start: !wait_r, op: AR_DIV, cap_neg: d_r[ax_r][47]};
        ar_b   = dd_r;
        ar_neg = d_r[ax_r][47];
      end
      S_K_WR: begin
        frc_we    = 1'b1;
        frc_waddr = k_r[BODY_W-1:0];
        frc_wdata = fk_r;
      end
      S_J_WR: begin
        frc_we = 1'b1;
      end
      S_B_K1, S_B_K2: begin
        ar_req = '{start: !wait_r, op: AR_MUL, cap_neg: fj_r[ax_r][47]};
        ar_a   = mag_q(fj_r[ax_r]);
        ar_b   = {1'b0, ts_r};
        ar_neg = fj_r[ax_r][47];
      end
      S_B_MV: begin
        ar_req = '{start: !wait_r, op: AR_MUL, cap_neg: vj_r[ax_r][47]};
        ar_a   = mag_q(vj_r[ax_r]);
        ar_b   = {1'b0, ts_r};
        ar_neg = vj_r[ax_r][47];
      end
      S_B_GWT: begin
        grid_we = ingrid_r && !grid_rd[BODY_W];
        mark_we = ingrid_r && !grid_rd[BODY_W];
      end
      S_B_ORD: begin
        vel_raddr = owner_r;
      end
      S_B_WR: begin
        pos_we = 1'b1;
        vel_we = 1'b1;
      end
      S_B_WR2: begin
        vel_we    = 1'b1;
        vel_waddr = owner_r;
        vel_wdata = vj_r;
      end
      S_MC_WR: begin
        grid_we    = 1'b1;
        grid_waddr = mark_rd;
        grid_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_GCLR;
      clr_r       <= '0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ts_r        <= TS_W'(167772160);
      nbod_r      <= CNT_W'(1000);
    end else begin
      st_r <= st_nxt;
      if (st_r == S_GCLR) clr_r <= clr_r + 1'b1;
      // arithmetic request handshake
      if (ar_req.start) begin
        wait_r <= 1'b1;
      end else if (step_done) begin
        wait_r <= 1'b0;
      end
      // configuration
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TIME_STEP: ts_r   <= cfg_data;
          CFG_BODIES:    nbod_r <= cfg_data[CNT_W-1:0];
          default:       ts_r   <= ts_r;
        endcase
      end
      // output register
      if (st_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (st_r == S_FIN && out_free) out_r <= res_r;
    unique case (st_r)
      S_IDLE: begin
        rd_ok_r    <= ({1'b0, in_data.body} < 11'(MAX_BODIES));
        j_r        <= '0;
        coll_r     <= '0;
        mark_cnt_r <= '0;
        n_r        <= (nbod_r > CNT_W'(MAX_BODIES)) ? CNT_W'(MAX_BODIES) : nbod_r;
      end
      S_RD_WAIT: begin
        res_r.out_x           <= rd_ok_r ? pos_rd[0] : '0;
        res_r.out_y           <= rd_ok_r ? pos_rd[1] : '0;
        res_r.out_z           <= rd_ok_r ? pos_rd[2] : '0;
        res_r.collision_count <= '0;
      end
      S_FCLR: begin
        j_r <= (j_r < n_r) ? j_r + 1'b1 : '0;
      end
      S_J_RD: begin
        if (j_r >= n_r) j_r <= '0;
      end
      S_J_WAIT: begin
        pj_r <= pos_rd;
        fj_r <= frc_rd;
        k_r  <= j_r + 1'b1;
      end
      S_K_WAIT: begin
        fk_r   <= frc_rd;
        d_r    <= d_new;
        dist_r <= '0;
        ax_r   <= 2'd0;
      end
      S_K_SQ: begin
        if (step_done) begin
          dist_r <= ({1'b0, dist_r} + {1'b0, ar_res} > {1'b0, UCAPP}) ? UCAPP
                    : 48'(dist_r + ar_res);
          ax_r   <= ax_last ? 2'd0 : ax_r + 2'd1;
        end
      end
      S_K_DD: begin
        if (step_done) dd_r <= ar_res;
      end
      S_K_DIV: begin
        if (step_done) begin
          fj_r[ax_r] <= sat_q(sext50(fj_r[ax_r]) + ar_s);
          fk_r[ax_r] <= sat_q(sext50(fk_r[ax_r]) - ar_s);
          ax_r       <= ax_last ? 2'd0 : ax_r + 2'd1;
        end
      end
      S_K_WR: begin
        k_r <= k_r + 1'b1;
      end
      S_J_WR: begin
        j_r <= j_r + 1'b1;
      end
      S_B_RD: begin
        k_r <= '0;
      end
      S_B_WAIT: begin
        pj_r <= pos_rd;
        vj_r <= vel_rd;
        fj_r <= frc_rd;
        ax_r <= 2'd0;
      end
      S_B_K1, S_B_K2: begin
        if (step_done) begin
          vj_r[ax_r] <= sat_q(sext50(vj_r[ax_r]) + ar_half);
          ax_r       <= ax_last ? 2'd0 : ax_r + 2'd1;
        end
      end
      S_B_MV: begin
        if (step_done) begin
          pj_r[ax_r] <= sat_q(sext50(pj_r[ax_r]) + ar_s);
          ax_r       <= ax_last ? 2'd0 : ax_r + 2'd1;
        end
      end
      S_B_GRD: begin
        cell_r   <= cell_new;
        ingrid_r <= in_grid;
      end
      S_B_GWT: begin
        hit_r   <= ingrid_r && grid_rd[BODY_W];
        owner_r <= grid_rd[BODY_W-1:0];
        if (ingrid_r && !grid_rd[BODY_W]) mark_cnt_r <= mark_cnt_r + 1'b1;
      end
      S_B_OWT: begin
        vo_r <= vel_rd;
      end
      S_B_WR: begin
        if (hit_r) begin
          coll_r <= coll_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      S_B_WR2: begin
        j_r <= j_r + 1'b1;
      end
      S_MC_RD: begin
        res_r <= '{out_x: '0, out_y: '0, out_z: '0, collision_count: coll_r};
      end
      S_MC_WR: begin
        k_r <= k_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // body memories
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    if (vel_we) vel_mem[vel_waddr] <= vel_wdata;
    if (frc_we) frc_mem[frc_waddr] <= frc_wdata;
    pos_rd <= pos_mem[pos_raddr];
    vel_rd <= vel_mem[vel_raddr];
    frc_rd <= frc_mem[frc_raddr];
  end

  // occupancy grid and list of claimed cells
  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
    if (mark_we) mark_mem[mark_waddr] <= cell_r;
    grid_rd <= grid_mem[grid_raddr];
    mark_rd <= mark_mem[mark_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

[rtl/core/nbsg_checker.sv]
// port-level checks of the n-body step block, bound to the top level
`default_nettype none
module nbsg_checker import nbsg_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // grid clearing after reset holds off input items
  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during grid clearing");

  // a load item gives no result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.op == OP_LOAD && !out_valid |=> !out_valid)
    else $error("load produced a result item");

  // a taken step item stalls the input side
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.op == OP_STEP |=> in_stall)
    else $error("input taken while a step runs");

endmodule

bind nbody_step_with_grid_collisions nbsg_checker u_nbsg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
`default_nettype wire
